### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the nesting tracker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TKD_ASSERT_RST(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TKD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/tkd_pkg.sv
// ----------------------------------------------------------------------------
// Token nesting depth tracker package
// Token codes, depth limits and the stack control and status records.
// ----------------------------------------------------------------------------
`default_nettype none

package tkd_pkg;

    // Default number of stored entries in each stack.
    localparam int unsigned TKD_STACK_DEPTH = 64;

    // Field widths.
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned DEPTH_W = 8;
    localparam int unsigned LEVEL_W = 9;

    // Saturation limit of the depth counters.
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'hFF;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_OTHER  = 4'd0;
    localparam logic [KIND_W-1:0] K_LBRACE = 4'd1;
    localparam logic [KIND_W-1:0] K_RBRACE = 4'd2;
    localparam logic [KIND_W-1:0] K_LPAREN = 4'd3;
    localparam logic [KIND_W-1:0] K_LBRK   = 4'd4;
    localparam logic [KIND_W-1:0] K_LBRK2  = 4'd5;
    localparam logic [KIND_W-1:0] K_RPAREN = 4'd6;
    localparam logic [KIND_W-1:0] K_RBRK   = 4'd7;
    localparam logic [KIND_W-1:0] K_RBRK2  = 4'd8;
    localparam logic [KIND_W-1:0] K_ELSE   = 4'd9;
    localparam logic [KIND_W-1:0] K_REPEAT = 4'd10;
    localparam logic [KIND_W-1:0] K_IF     = 4'd11;
    localparam logic [KIND_W-1:0] K_FOR    = 4'd12;
    localparam logic [KIND_W-1:0] K_WHILE  = 4'd13;

    // Commands from the tracker to one stack.
    typedef struct packed {
        logic take;   // a request is accepted this cycle
        logic clear;  // empty the stack before this request
        logic push;
        logic pop;
    } tkd_stk_cmd_t;

    // Stack status, as seen after an optional clear.
    typedef struct packed {
        logic empty;  // pointer is zero
        logic full;   // a push would be dropped
        logic over;   // pointer counts past the stored entries
    } tkd_stk_stat_t;

endpackage

`default_nettype wire

### sv/tkd_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// One stack entry; loads from its upper neighbor on a push and from its
// lower neighbor on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_cell #(
    parameter int unsigned DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              shift_dn,
    input  wire logic              shift_up,
    input  wire logic [DATA_W-1:0] prev_data,
    input  wire logic [DATA_W-1:0] next_data,
    output logic      [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Select the new entry value.
    always_comb
    begin
        data_next = data_reg;
        if (shift_dn)
        begin
            data_next = prev_data;
        end
        else if (shift_up)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### sv/tkd_stack.sv
// ----------------------------------------------------------------------------
// Shift stack
// A row of cells with the top entry in the first cell, plus a saturating
// pointer that keeps counting pushes that found the row full.
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_stack
    import tkd_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = TKD_STACK_DEPTH,
    parameter int unsigned DATA_W      = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tkd_stk_cmd_t      cmd,
    input  wire logic [DATA_W-1:0] wdata,
    output tkd_stk_stat_t          stat,
    output logic      [DATA_W-1:0] top
);

    localparam int unsigned PTR_W = $clog2(2 * STACK_DEPTH);
    localparam logic [PTR_W-1:0] PtrDepth = PTR_W'(STACK_DEPTH);
    localparam logic [PTR_W-1:0] PtrCap   = PTR_W'(2 * STACK_DEPTH - 1);

    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [PTR_W-1:0]  ptr_eff;
    logic              shift_dn;
    logic              shift_up;
    logic [DATA_W-1:0] cell_q [STACK_DEPTH];

    // Status after the optional clear.
    assign ptr_eff    = cmd.clear ? '0 : ptr_reg;
    assign stat.empty = (ptr_eff == '0);
    assign stat.full  = (ptr_eff >= PtrDepth);
    assign stat.over  = (ptr_eff > PtrDepth);

    // Entries move only while the pointer is within the stored range.
    assign shift_dn = cmd.take && cmd.push && !stat.full;
    assign shift_up = cmd.take && cmd.pop && !stat.empty && !stat.over;

    // Pointer update.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.take)
        begin
            ptr_next = ptr_eff;
            if (cmd.push && (ptr_eff != PtrCap))
            begin
                ptr_next = ptr_eff + 1'b1;
            end
            else if (cmd.pop && !stat.empty)
            begin
                ptr_next = ptr_eff - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // Row of cells, top of stack in cell 0.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] from_prev;
        logic [DATA_W-1:0] from_next;

        if (i == 0)
        begin : g_first
            assign from_prev = wdata;
        end
        else
        begin : g_mid
            assign from_prev = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign from_next = cell_q[i];
        end
        else
        begin : g_inner
            assign from_next = cell_q[i+1];
        end

        tkd_cell #(
            .DATA_W (DATA_W)
        ) u_cell (
            .clk       (clk),
            .shift_dn  (shift_dn),
            .shift_up  (shift_up),
            .prev_data (from_prev),
            .next_data (from_next),
            .data      (cell_q[i])
        );
    end

    assign top = cell_q[0];

endmodule

`default_nettype wire

### sv/token_nesting_depth_tracker.sv
// ----------------------------------------------------------------------------
// Token nesting depth tracker: one request per cycle unless the output stalls, result in the next cycle.
// Both stack tops sit in the first cell of a row of shift cells.
// Reset (async, active low) clears depths, pointers and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module token_nesting_depth_tracker
    import tkd_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = TKD_STACK_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [KIND_W-1:0]  token_kind,
    input  wire logic               start_of_list,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [DEPTH_W-1:0] curly_depth,
    output logic      [DEPTH_W-1:0] bracket_depth,
    output logic      [DEPTH_W-1:0] enclosing_base,
    output logic      [LEVEL_W-1:0] nest_level,
    output logic                    stack_overflow
);

    logic               accept;
    logic [DEPTH_W-1:0] brace_reg, brace_next, brace_eff;
    logic [DEPTH_W-1:0] bracket_reg, bracket_next, bracket_eff;
    logic [KIND_W-1:0]  prev_reg, prev_next, prev_eff;
    logic               lcc_reg, lcc_next, lcc_eff;
    logic [DEPTH_W-1:0] base;
    logic [DEPTH_W-1:0] over_base;
    logic [LEVEL_W-1:0] level;
    logic               ctrl_brace;
    logic               ctrl_paren;
    logic               ovf;
    logic [1:0]         brk_up;
    logic [1:0]         brk_dn;
    logic [DEPTH_W:0]   brk_sum;

    tkd_stk_cmd_t       base_cmd;
    tkd_stk_stat_t      base_stat;
    logic [DEPTH_W-1:0] base_top;
    logic [DEPTH_W-1:0] base_wdata;
    tkd_stk_cmd_t       paren_cmd;
    tkd_stk_stat_t      paren_stat;
    logic [0:0]         paren_top;

    logic               out_valid_reg;
    logic [DEPTH_W-1:0] brace_out_reg;
    logic [DEPTH_W-1:0] bracket_out_reg;
    logic [DEPTH_W-1:0] base_out_reg;
    logic [LEVEL_W-1:0] level_out_reg;
    logic               ovf_out_reg;

    // A new request is taken whenever the output register is free or drains.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // State as seen by this request, after an optional start of list.
    assign brace_eff   = start_of_list ? '0 : brace_reg;
    assign bracket_eff = start_of_list ? '0 : bracket_reg;
    assign prev_eff    = start_of_list ? K_OTHER : prev_reg;
    assign lcc_eff     = start_of_list ? 1'b0 : lcc_reg;

    // Enclosing base and nesting level before this token.
    assign base      = base_stat.empty ? '0 : base_top;
    assign over_base = (bracket_eff > base) ? (bracket_eff - base) : '0;
    assign level     = {1'b0, brace_eff} + {1'b0, over_base};

    // A brace after else, repeat or a control paren inherits the base.
    assign ctrl_brace = (prev_eff == K_ELSE) || (prev_eff == K_REPEAT) ||
                        ((prev_eff == K_RPAREN) && lcc_eff);
    assign ctrl_paren = prev_eff inside {K_IF, K_FOR, K_WHILE};
    assign base_wdata = ctrl_brace ? base : bracket_eff;

    // Stack commands.
    assign base_cmd.take   = accept;
    assign base_cmd.clear  = start_of_list;
    assign base_cmd.push   = (token_kind == K_LBRACE);
    assign base_cmd.pop    = (token_kind == K_RBRACE);
    assign paren_cmd.take  = accept;
    assign paren_cmd.clear = start_of_list;
    assign paren_cmd.push  = (token_kind == K_LPAREN);
    assign paren_cmd.pop   = (token_kind == K_RPAREN);

    assign ovf = (base_cmd.push && base_stat.full) || (paren_cmd.push && paren_stat.full);

    tkd_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_W      (DEPTH_W)
    ) u_base_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (base_cmd),
        .wdata (base_wdata),
        .stat  (base_stat),
        .top   (base_top)
    );

    tkd_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_W      (1)
    ) u_paren_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (paren_cmd),
        .wdata (ctrl_paren),
        .stat  (paren_stat),
        .top   (paren_top)
    );

    // Bracket step sizes for this token.
    always_comb
    begin
        brk_up = 2'd0;
        brk_dn = 2'd0;
        unique case (token_kind)
            K_LPAREN, K_LBRK: brk_up = 2'd1;
            K_LBRK2:          brk_up = 2'd2;
            K_RPAREN, K_RBRK: brk_dn = 2'd1;
            K_RBRK2:          brk_dn = 2'd2;
            default:          brk_up = 2'd0;
        endcase
    end

    assign brk_sum = {1'b0, bracket_eff} + (DEPTH_W + 1)'(brk_up);

    // Next tracker state.
    always_comb
    begin
        brace_next = brace_eff;
        if (token_kind == K_LBRACE)
        begin
            brace_next = (brace_eff == DEPTH_MAX) ? DEPTH_MAX : brace_eff + 1'b1;
        end
        else if (token_kind == K_RBRACE)
        begin
            brace_next = (brace_eff == '0) ? '0 : brace_eff - 1'b1;
        end

        if (brk_dn != 2'd0)
        begin
            bracket_next = (bracket_eff > DEPTH_W'(brk_dn)) ?
                           bracket_eff - DEPTH_W'(brk_dn) : '0;
        end
        else
        begin
            bracket_next = brk_sum[DEPTH_W] ? DEPTH_MAX : brk_sum[DEPTH_W-1:0];
        end

        lcc_next = lcc_eff;
        if (token_kind == K_RPAREN)
        begin
            lcc_next = !paren_stat.empty && !paren_stat.over && paren_top[0];
        end

        prev_next = (token_kind > K_WHILE) ? K_OTHER : token_kind;
    end

    // Tracker registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brace_reg   <= '0;
            bracket_reg <= '0;
            prev_reg    <= K_OTHER;
            lcc_reg     <= 1'b0;
        end
        else if (accept)
        begin
            brace_reg   <= brace_next;
            bracket_reg <= bracket_next;
            prev_reg    <= prev_next;
            lcc_reg     <= lcc_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            brace_out_reg   <= brace_eff;
            bracket_out_reg <= bracket_eff;
            base_out_reg    <= base;
            level_out_reg   <= level;
            ovf_out_reg     <= ovf;
        end
    end

    assign out_valid      = out_valid_reg;
    assign curly_depth    = brace_out_reg;
    assign bracket_depth  = bracket_out_reg;
    assign enclosing_base = base_out_reg;
    assign nest_level     = level_out_reg;
    assign stack_overflow = ovf_out_reg;

endmodule

`default_nettype wire

### sv/tkd_checker.sv
// ----------------------------------------------------------------------------
// Nesting tracker checker
// Port-level assertions on the tracker, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tkd_checker
    import tkd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               start_of_list,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [DEPTH_W-1:0] curly_depth,
    input wire logic [DEPTH_W-1:0] bracket_depth,
    input wire logic [DEPTH_W-1:0] enclosing_base,
    input wire logic [LEVEL_W-1:0] nest_level,
    input wire logic               stack_overflow
);

    // A stalled result holds its payload.
    `TKD_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable({curly_depth, bracket_depth, enclosing_base, nest_level, stack_overflow}), "stalled result changed")

    // Every accepted request yields a result in the next cycle.
    `TKD_ASSERT_RST(a_accept_result, clk, rst_n, in_valid && !in_stall |=> out_valid, "accepted request gave no result")

    // A request that starts a list reports an empty nesting state.
    `TKD_ASSERT_RST(a_list_start, clk, rst_n, in_valid && !in_stall && start_of_list |=> curly_depth == '0 && bracket_depth == '0 && enclosing_base == '0 && nest_level == '0, "list start not cleared")

    // The nesting level is the brace depth plus brackets above the base.
    `TKD_ASSERT_ALWAYS(a_level_sum, clk, out_valid |-> nest_level == ({1'b0, curly_depth} + ((bracket_depth > enclosing_base) ? {1'b0, bracket_depth - enclosing_base} : {LEVEL_W{1'b0}})), "nesting level mismatch")

endmodule

bind token_nesting_depth_tracker tkd_checker u_tkd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .start_of_list  (start_of_list),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .curly_depth    (curly_depth),
    .bracket_depth  (bracket_depth),
    .enclosing_base (enclosing_base),
    .nest_level     (nest_level),
    .stack_overflow (stack_overflow)
);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Token nesting depth tracker testbench
// Sends classified token requests through the tracker in random bursts with
// idle gaps while the receiver stalls in patterns of its own. A local
// model of the depth counters, base stack and control paren stack predicts every
// result not fixed in a directed row; each returned result is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import tkd_pkg::*;

    localparam int unsigned STK          = TKD_STACK_DEPTH;
    localparam int unsigned PTR_CAP      = 2 * STK - 1;
    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned TAIL_CYCLES  = 4;

    // Kinds with no meaning of their own; the tracker treats them as other.
    localparam logic [KIND_W-1:0] K_SPARE_LO = 4'd14;
    localparam logic [KIND_W-1:0] K_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [DEPTH_W-1:0] brace;
        logic [DEPTH_W-1:0] bracket;
        logic [DEPTH_W-1:0] base;
        logic [LEVEL_W-1:0] level;
        logic               overflow;
    } depth_report_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              clear;
        logic              fixed;  // expectation given in the row itself
        depth_report_t     want;
    } token_row_t;

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    localparam depth_report_t AT_REST = '0;

    // Directed requests: empty-state pops, every kind, control heads, clears.
    token_row_t directed_rows [25] = '{
        '{K_OTHER,    1'b1, 1'b1, AT_REST},
        '{K_RBRACE,   1'b0, 1'b1, AT_REST},
        '{K_RPAREN,   1'b0, 1'b1, AT_REST},
        '{K_RBRK,     1'b0, 1'b1, AT_REST},
        '{K_RBRK2,    1'b0, 1'b1, AT_REST},
        '{K_IF,       1'b0, 1'b1, AT_REST},
        '{K_LPAREN,   1'b0, 1'b1, AT_REST},
        '{K_LBRK2,    1'b0, 1'b0, AT_REST},
        '{K_RBRK2,    1'b0, 1'b0, AT_REST},
        '{K_RPAREN,   1'b0, 1'b0, AT_REST},
        '{K_LBRACE,   1'b0, 1'b0, AT_REST},
        '{K_LBRK,     1'b0, 1'b0, AT_REST},
        '{K_LBRACE,   1'b0, 1'b0, AT_REST},
        '{K_RBRACE,   1'b0, 1'b0, AT_REST},
        '{K_RBRACE,   1'b0, 1'b0, AT_REST},
        '{K_RBRK,     1'b0, 1'b0, AT_REST},
        '{K_ELSE,     1'b0, 1'b0, AT_REST},
        '{K_LBRACE,   1'b0, 1'b0, AT_REST},
        '{K_REPEAT,   1'b0, 1'b0, AT_REST},
        '{K_LBRACE,   1'b0, 1'b0, AT_REST},
        '{K_FOR,      1'b0, 1'b0, AT_REST},
        '{K_WHILE,    1'b0, 1'b0, AT_REST},
        '{K_SPARE_LO, 1'b0, 1'b0, AT_REST},
        '{K_SPARE_HI, 1'b0, 1'b0, AT_REST},
        '{K_OTHER,    1'b1, 1'b1, AT_REST}
    };

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [KIND_W-1:0]   token_kind    = K_OTHER;
    logic                start_of_list = 1'b0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [DEPTH_W-1:0]  curly_depth;
    logic [DEPTH_W-1:0]  bracket_depth;
    logic [DEPTH_W-1:0]  enclosing_base;
    logic [LEVEL_W-1:0]  nest_level;
    logic                stack_overflow;

    // Tracker model state.
    int unsigned         brace_cnt;
    int unsigned         brk_cnt;
    int unsigned         base_ptr;
    int unsigned         paren_ptr;
    logic [KIND_W-1:0]   prev_kind;
    logic [DEPTH_W-1:0]  base_mem [STK];
    logic                ctl_mem [STK];
    logic                last_close_ctl;

    depth_report_t       pending_depths [$];
    int unsigned         error_count = 0;
    int unsigned         items_sent  = 0;
    int unsigned         cycle_count = 0;
    int unsigned         burst_left  = 1;
    logic                clear_next  = 1'b0;
    rx_mode_t            rx_mode     = RX_FREE;
    int unsigned         rx_left     = 0;

    token_nesting_depth_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .token_kind     (token_kind),
        .start_of_list  (start_of_list),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .curly_depth    (curly_depth),
        .bracket_depth  (bracket_depth),
        .enclosing_base (enclosing_base),
        .nest_level     (nest_level),
        .stack_overflow (stack_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Empty stacks, zero depths and no previous token.
    function automatic void reset_tracker();
        brace_cnt      = 0;
        brk_cnt        = 0;
        base_ptr       = 0;
        paren_ptr      = 0;
        prev_kind      = K_OTHER;
        last_close_ctl = 1'b0;
    endfunction

    function automatic int unsigned depth_up(input int unsigned v, input int unsigned d);
        return (v + d > DEPTH_MAX) ? DEPTH_MAX : v + d;
    endfunction

    function automatic int unsigned depth_down(input int unsigned v, input int unsigned d);
        return (v > d) ? v - d : 0;
    endfunction

    // Reports the state seen before the token, then applies the token.
    function automatic depth_report_t track_token(input logic [KIND_W-1:0] kind,
                                                  input logic clear);
        depth_report_t r;
        int unsigned   top;
        logic          ctl;
        if (clear)
            reset_tracker();

        // Past the stored entries the topmost stored base stays in force.
        if (base_ptr == 0)
            top = 0;
        else
            top = base_mem[(base_ptr > STK ? STK : base_ptr) - 1];

        r.brace    = DEPTH_W'(brace_cnt);
        r.bracket  = DEPTH_W'(brk_cnt);
        r.base     = DEPTH_W'(top);
        r.level    = LEVEL_W'(brace_cnt + (brk_cnt > top ? brk_cnt - top : 0));
        r.overflow = 1'b0;

        case (kind)
            K_LBRACE:
            begin
                // A control body keeps the enclosing base.
                ctl = (prev_kind == K_ELSE) || (prev_kind == K_REPEAT) ||
                      (prev_kind == K_RPAREN && last_close_ctl);
                if (base_ptr < STK)
                    base_mem[base_ptr] = DEPTH_W'(ctl ? top : brk_cnt);
                else
                    r.overflow = 1'b1;
                if (base_ptr < PTR_CAP)
                    base_ptr++;
                brace_cnt = depth_up(brace_cnt, 1);
            end
            K_RBRACE:
            begin
                brace_cnt = depth_down(brace_cnt, 1);
                if (base_ptr > 0)
                    base_ptr--;
            end
            K_LPAREN:
            begin
                if (paren_ptr < STK)
                    ctl_mem[paren_ptr] = (prev_kind == K_IF) || (prev_kind == K_FOR) ||
                                         (prev_kind == K_WHILE);
                else
                    r.overflow = 1'b1;
                if (paren_ptr < PTR_CAP)
                    paren_ptr++;
                brk_cnt = depth_up(brk_cnt, 1);
            end
            K_LBRK:
                brk_cnt = depth_up(brk_cnt, 1);
            K_LBRK2:
                brk_cnt = depth_up(brk_cnt, 2);
            K_RPAREN:
            begin
                // A dropped entry, or no entry at all, carries no control bit.
                if (paren_ptr > 0)
                begin
                    paren_ptr--;
                    last_close_ctl = (paren_ptr < STK) ? ctl_mem[paren_ptr] : 1'b0;
                end
                else
                    last_close_ctl = 1'b0;
                brk_cnt = depth_down(brk_cnt, 1);
            end
            K_RBRK:
                brk_cnt = depth_down(brk_cnt, 1);
            K_RBRK2:
                brk_cnt = depth_down(brk_cnt, 2);
            default:
                ;
        endcase
        prev_kind = (kind >= K_SPARE_LO) ? K_OTHER : kind;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_result(input depth_report_t want);
        if (curly_depth !== want.brace)
            report_mismatch($sformatf("curly_depth %0d, expected %0d",
                                      curly_depth, want.brace));
        if (bracket_depth !== want.bracket)
            report_mismatch($sformatf("bracket_depth %0d, expected %0d",
                                      bracket_depth, want.bracket));
        if (enclosing_base !== want.base)
            report_mismatch($sformatf("enclosing_base %0d, expected %0d",
                                      enclosing_base, want.base));
        if (nest_level !== want.level)
            report_mismatch($sformatf("nest_level %0d, expected %0d",
                                      nest_level, want.level));
        if (stack_overflow !== want.overflow)
            report_mismatch($sformatf("stack_overflow %0d, expected %0d",
                                      stack_overflow, want.overflow));
    endtask

    // Present one request, hold it until accepted, then idle if the burst ends.
    task automatic send_token(input logic [KIND_W-1:0] kind, input logic clear,
                              input logic fixed, input depth_report_t want);
        depth_report_t predicted;
        in_valid      <= 1'b1;
        token_kind    <= kind;
        start_of_list <= clear;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted = track_token(kind, clear);
        pending_depths.insert(pending_depths.size(), fixed ? want : predicted);
        items_sent++;
        burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(8, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(50, 200);
            else
                burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic emit(input logic [KIND_W-1:0] kind);
        send_token(kind, clear_next, 1'b0, AT_REST);
        clear_next = 1'b0;
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_depths.size() != 0);
    endtask

    // An expression with calls, indexing and the odd braced argument.
    task automatic gen_expression(input int unsigned len);
        logic [KIND_W-1:0] closers [$];
        int unsigned       pick;
        repeat (len)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                emit(K_OTHER);
            else if (pick == 3)
            begin
                emit(K_OTHER);
                emit(K_LPAREN);
                closers.insert(closers.size(), K_RPAREN);
            end
            else if (pick == 4)
            begin
                emit(K_LBRK);
                closers.insert(closers.size(), K_RBRK);
            end
            else if (pick == 5)
            begin
                emit(K_LBRK2);
                closers.insert(closers.size(), K_RBRK2);
            end
            else if (pick == 6)
            begin
                emit(K_LPAREN);
                closers.insert(closers.size(), K_RPAREN);
            end
            else if (pick == 7 && closers.size() != 0)
            begin
                // Braced body inside an argument list takes its own base.
                emit(K_LBRACE);
                emit(K_OTHER);
                emit(K_LBRK);
                emit(K_RBRK);
                emit(K_RBRACE);
            end
            else if (closers.size() != 0)
            begin
                emit(closers[closers.size() - 1]);
                closers.delete(closers.size() - 1);
            end
            else
                emit(K_OTHER);
        end
        while (closers.size() != 0)
        begin
            emit(closers[closers.size() - 1]);
            closers.delete(closers.size() - 1);
        end
    endtask

    // Statements with if/for/while/repeat heads, bodies and else branches.
    task automatic gen_snippet();
        logic              open_ifs [$];  // one per open block, set if an if opened it
        int unsigned       stmts;
        int unsigned       pick;
        logic              broken;
        logic              was_if;
        logic [KIND_W-1:0] head;
        stmts  = $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        while (stmts != 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35 && open_ifs.size() < 6)
            begin
                case ($urandom_range(0, 4))
                    0: head = K_IF;
                    1: head = K_FOR;
                    2: head = K_WHILE;
                    3: head = K_REPEAT;
                    default: head = K_OTHER;
                endcase
                // A head of other stands for a bare block.
                if (head != K_OTHER)
                    emit(head);
                if (head == K_IF || head == K_FOR || head == K_WHILE)
                begin
                    emit(K_LPAREN);
                    gen_expression($urandom_range(0, 4));
                    emit(K_RPAREN);
                end
                emit(K_LBRACE);
                open_ifs.insert(open_ifs.size(), head == K_IF);
            end
            else if (pick < 75 || open_ifs.size() == 0)
            begin
                gen_expression($urandom_range(1, 6));
                stmts--;
            end
            else
            begin
                emit(K_RBRACE);
                was_if = open_ifs[open_ifs.size() - 1];
                open_ifs.delete(open_ifs.size() - 1);
                if (was_if && $urandom_range(0, 1) == 1)
                begin
                    emit(K_ELSE);
                    emit(K_LBRACE);
                    open_ifs.insert(open_ifs.size(), 1'b0);
                end
            end
        end

        // A broken snippet leaves blocks open or closes what was never opened.
        if (broken)
        begin
            repeat ($urandom_range(1, 3))
                emit($urandom_range(0, 1) == 1 ? K_RPAREN : K_RBRACE);
            if ($urandom_range(0, 1) == 1)
                open_ifs.delete();
        end
        while (open_ifs.size() != 0)
        begin
            open_ifs.delete(open_ifs.size() - 1);
            emit(K_RBRACE);
        end
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(4, 24))
        begin
            if ($urandom_range(0, 29) == 0)
                clear_next = 1'b1;
            emit(KIND_W'($urandom_range(0, 15)));
        end
    endtask

    // Long runs that fill the stacks and saturate the depths.
    task automatic gen_deep_nesting(input int unsigned variant);
        int unsigned n;
        case (variant)
            0:
            begin
                // Stored bases stay zero so the level can reach its top.
                for (int unsigned i = 0; i < 260; i++)
                begin
                    if (i >= STK)
                    begin
                        case ($urandom_range(0, 11))
                            0: emit(K_ELSE);
                            1: emit(K_REPEAT);
                            2: emit(K_RPAREN);
                            3: emit(K_LBRK);
                            default: ;
                        endcase
                    end
                    emit(K_LBRACE);
                end
                repeat (130) emit(K_LBRK2);
                emit(K_OTHER);
                repeat (3) emit(K_RBRK2);
                repeat ($urandom_range(130, 140)) emit(K_RBRACE);
            end
            1:
            begin
                // Paren stack overflow; closes of dropped entries lose the head.
                n = $urandom_range(66, 80);
                repeat (n)
                begin
                    case ($urandom_range(0, 3))
                        0: emit(K_IF);
                        1: emit(K_FOR);
                        2: emit(K_WHILE);
                        default: emit(K_OTHER);
                    endcase
                    emit(K_LPAREN);
                end
                repeat (n + 2)
                begin
                    emit(K_RPAREN);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        emit(K_LBRACE);
                        emit(K_OTHER);
                        emit(K_RBRACE);
                    end
                end
            end
            default:
            begin
                // Base stack filled to or just past full with mixed control and plain opens.
                n = $urandom_range(64, 72);
                repeat (n)
                begin
                    case ($urandom_range(0, 5))
                        0: emit(K_ELSE);
                        1: emit(K_REPEAT);
                        2: emit(K_LBRK);
                        3: emit(K_RBRK);
                        default: ;
                    endcase
                    emit(K_LBRACE);
                end
                repeat (n + 1) emit(K_RBRACE);
            end
        endcase
    endtask

    // Result checking, receiver stalls and the cycle limit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
            begin
                if (out_valid === 1'b1 && out_stall === 1'b0)
                begin
                    if (pending_depths.size() == 0)
                        report_mismatch("result with no request outstanding");
                    else
                        check_result(pending_depths.pop_front());
                end

                // The receiver switches between stall patterns now and then.
                if (rx_left == 0)
                begin
                    rx_mode <= rx_mode_t'($urandom_range(0, 3));
                    rx_left <= $urandom_range(50, 300);
                end
                else
                    rx_left <= rx_left - 1;
                case (rx_mode)
                    RX_FREE:     out_stall <= 1'b0;
                    RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: out_stall <= (cycle_count % 5 < 2);
                endcase
            end
        end
    end

    // Reset, directed requests, random requests, then drain and verdict.
    initial
    begin
        int unsigned seq_count;
        int unsigned deep_count;
        seq_count  = 0;
        deep_count = 0;
        reset_tracker();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_token(directed_rows[i].kind, directed_rows[i].clear,
                       directed_rows[i].fixed, directed_rows[i].want);
        wait_for_drain();

        while (items_sent < $size(directed_rows) + RANDOM_ITEMS)
        begin
            clear_next = ($urandom_range(0, 7) == 0);
            if (seq_count % 15 == 1)
            begin
                gen_deep_nesting(deep_count % 3);
                deep_count++;
            end
            else if ($urandom_range(0, 99) < 80)
                gen_snippet();
            else
                gen_noise();
            if ($urandom_range(0, 39) == 0)
                wait_for_drain();
            seq_count++;
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
